// ===== rtl/core/mbt_pkg.sv =====
// Package for the escape-time membership test: item types, fixed-point
// constants and the sequencer state type. No dependencies.
package mbt_pkg;

    localparam int PIX_W     = 10;
    localparam int Z_W       = 32;
    localparam int PROD_W    = 2 * Z_W;
    localparam int FRAC_BITS = 28;
    localparam int ROUNDS_W  = 12;
    localparam int WIDE_W    = 40;
    localparam int MAG_W     = PROD_W - FRAC_BITS + 1;

    localparam logic [ROUNDS_W-1:0] RESET_ROUNDS = ROUNDS_W'(500);
    // Escape threshold |z|^2 > 4 in the same fixed-point scale.
    localparam logic [MAG_W-1:0]    ESC_LIMIT    = MAG_W'(4) << FRAC_BITS;

    typedef struct packed {
        logic [PIX_W-1:0]     pixel_x;
        logic [PIX_W-1:0]     pixel_y;
        logic signed [Z_W-1:0] c_real;
        logic signed [Z_W-1:0] c_imag;
    } t_in_item;

    typedef struct packed {
        logic [PIX_W-1:0] out_x;
        logic [PIX_W-1:0] out_y;
        logic             in_set;
    } t_out_item;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SQR_R,
        ST_SQR_I,
        ST_CROSS,
        ST_UPDATE
    } t_state;

    typedef enum logic [1:0] {
        MUL_RR,
        MUL_II,
        MUL_RI
    } t_mul_sel;

endpackage

// ===== rtl/core/mandelbrot_membership_test_top.sv =====
// Escape-time membership test for one point per item, built around one
// shared 32x32 signed multiplier. Depends on mbt_pkg.
//
// Input channel: i_in_valid / o_in_stall carry a t_in_item holding the
// pixel position and c in signed Q3.28. An item is taken at a clock edge
// where i_in_valid is high and o_in_stall is low; o_in_stall stays high
// for the whole time the block iterates on an item.
// Output channel: o_out_valid / i_out_stall carry a t_out_item with the
// pixel position and the in_set flag from an output register, so a new
// item is taken while an earlier result still waits.
// Configuration: i_cfg_we writes i_cfg_wdata into the round limit; write
// it only while the block is idle. Reset sets the limit to 500.
// Sequencing: the shared multiplier sets the pace. Each round of z = z*z + c
// passes through ST_SQR_R, ST_SQR_I and ST_CROSS for the three products
// and ST_UPDATE for the update of z. An item ends in ST_CROSS once it
// escapes or has run all max_rounds rounds; the sequencer then returns to
// ST_IDLE, where the next item can be taken.
// Reset (synchronous, active low) returns the sequencer to idle and clears
// the output valid. If the receiver stalls, the finished result of the
// next item waits inside the block until the output register frees.
module mandelbrot_membership_test_top
    import mbt_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  t_in_item            i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output t_out_item           o_out_item,
    input  logic                i_cfg_we,
    input  logic [ROUNDS_W-1:0] i_cfg_wdata
);

    // Control state.
    t_state                r_state, n_state;
    logic [ROUNDS_W-1:0]   r_max_rounds;
    logic [ROUNDS_W-1:0]   r_count;
    logic                  r_out_valid;

    // Datapath registers.
    logic [PIX_W-1:0]      r_px, r_py;
    logic signed [Z_W-1:0] r_c_real, r_c_imag;
    logic signed [Z_W-1:0] r_zr, r_zi;
    logic signed [PROD_W-1:0] r_rr, r_ii, r_ri;
    t_out_item             r_out_item;

    // Sequencer outputs.
    t_mul_sel              w_mul_sel;
    logic                  w_finish;
    logic                  w_escaped;
    logic                  w_out_free;
    logic                  w_accept;

    logic signed [Z_W-1:0]    w_op_a, w_op_b;
    logic signed [PROD_W-1:0] w_prod;
    logic signed [PROD_W-1:0] w_diff, w_diff_sh, w_ri_sh;
    logic signed [WIDE_W-1:0] w_nr_wide, w_ni_wide;
    logic [MAG_W-1:0]         w_mag;

    function automatic logic signed [Z_W-1:0] sat_z(input logic signed [WIDE_W-1:0] v);
        logic signed [Z_W-1:0] res;
        if (v[WIDE_W-1:Z_W-1] == {(WIDE_W-Z_W+1){v[WIDE_W-1]}}) begin
            res = v[Z_W-1:0];
        end else if (v[WIDE_W-1]) begin
            res = {1'b1, {(Z_W-1){1'b0}}};
        end else begin
            res = {1'b0, {(Z_W-1){1'b1}}};
        end
        return res;
    endfunction

    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_accept   = i_in_valid && (r_state == ST_IDLE);

    // Shared multiplier with its operand select.
    always_comb begin
        unique case (w_mul_sel)
            MUL_RR: begin
                w_op_a = r_zr;
                w_op_b = r_zr;
            end
            MUL_II: begin
                w_op_a = r_zi;
                w_op_b = r_zi;
            end
            MUL_RI: begin
                w_op_a = r_zr;
                w_op_b = r_zi;
            end
            default: begin
                w_op_a = r_zr;
                w_op_b = r_zi;
            end
        endcase
    end

    assign w_prod = w_op_a * w_op_b;

    // The squares of the current z serve both the escape test of the last
    // update and the next update itself.
    assign w_mag = MAG_W'(r_rr[PROD_W-1:FRAC_BITS]) + MAG_W'(r_ii[PROD_W-1:FRAC_BITS]);

    // Update of z from the registered products; arithmetic shifts floor.
    assign w_diff    = r_rr - r_ii;
    assign w_diff_sh = w_diff >>> FRAC_BITS;
    assign w_ri_sh   = r_ri >>> (FRAC_BITS - 1);
    assign w_nr_wide = $signed(w_diff_sh[WIDE_W-1:0]) + WIDE_W'(r_c_real);
    assign w_ni_wide = $signed(w_ri_sh[WIDE_W-1:0]) + WIDE_W'(r_c_imag);

    // Next-state logic.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ST_SQR_R;
                end
            end
            ST_SQR_R: begin
                n_state = ST_SQR_I;
            end
            ST_SQR_I: begin
                n_state = ST_CROSS;
            end
            ST_CROSS: begin
                if (w_finish) begin
                    if (w_out_free) begin
                        n_state = ST_IDLE;
                    end
                end else begin
                    n_state = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                n_state = ST_SQR_R;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Sequencer outputs: multiplier select and the end-of-item decision.
    always_comb begin
        w_mul_sel = MUL_RI;
        w_finish  = 1'b0;
        w_escaped = 1'b0;
        unique case (r_state)
            ST_SQR_R: begin
                w_mul_sel = MUL_RR;
            end
            ST_SQR_I: begin
                w_mul_sel = MUL_II;
            end
            ST_CROSS: begin
                w_mul_sel = MUL_RI;
                w_escaped = (r_count != '0) && (w_mag > ESC_LIMIT);
                w_finish  = w_escaped || (r_count == r_max_rounds);
            end
            ST_IDLE, ST_UPDATE: begin
                w_mul_sel = MUL_RI;
            end
            default: begin
                w_mul_sel = MUL_RI;
            end
        endcase
    end

    assign o_in_stall = (r_state != ST_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_max_rounds <= RESET_ROUNDS;
            r_count      <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_max_rounds <= i_cfg_wdata;
            end
            if (w_accept) begin
                r_count <= '0;
            end else if (r_state == ST_UPDATE) begin
                r_count <= r_count + ROUNDS_W'(1);
            end
            if (r_state == ST_CROSS && w_finish && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_px     <= i_in_item.pixel_x;
            r_py     <= i_in_item.pixel_y;
            r_c_real <= i_in_item.c_real;
            r_c_imag <= i_in_item.c_imag;
            r_zr     <= '0;
            r_zi     <= '0;
        end else if (r_state == ST_UPDATE) begin
            r_zr <= sat_z(w_nr_wide);
            r_zi <= sat_z(w_ni_wide);
        end
        unique case (w_mul_sel)
            MUL_RR: r_rr <= w_prod;
            MUL_II: r_ii <= w_prod;
            MUL_RI: begin
                if (r_state == ST_CROSS) begin
                    r_ri <= w_prod;
                end
            end
            default: begin
                r_ri <= r_ri;
            end
        endcase
        if (r_state == ST_CROSS && w_finish && w_out_free) begin
            r_out_item.out_x  <= r_px;
            r_out_item.out_y  <= r_py;
            r_out_item.in_set <= !w_escaped;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

// ===== tb/sv/mandelbrot_membership_test_top_tb.sv =====
// Self-checking testbench for mandelbrot_membership_test_top: directed and random
// points, several round limits and receiver back-pressure, each result checked against a
// known answer or a local escape-time predictor. Depends on mbt_pkg and the block itself.
module mandelbrot_membership_test_top_tb;
    import mbt_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // One unit in signed Q3.28 and a few handy points of the plane.
    localparam int              ONE     = 1 << FRAC_BITS;
    localparam logic signed [31:0] Q_ONE = 32'sh1000_0000;
    localparam logic signed [31:0] Q_TWO = 32'sh2000_0000;
    localparam logic signed [31:0] Q_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;
    localparam longint          Z_HI    = 64'sh0000_0000_7FFF_FFFF;
    localparam longint          Z_LO    = -64'sh0000_0000_8000_0000;
    localparam longint          BAILOUT = 64'sd4 <<< FRAC_BITS;

    // Directed points. Where known is set, in_set is the obvious answer for any
    // round limit above one; the other rows go through the predictor.
    typedef struct packed {
        logic [PIX_W-1:0]      px;
        logic [PIX_W-1:0]      py;
        logic signed [Z_W-1:0] cr;
        logic signed [Z_W-1:0] ci;
        logic                  known;
        logic                  in_set;
    } t_probe;

    localparam int N_PROBES = 18;
    localparam t_probe PROBES [N_PROBES] = '{
        '{10'd0,    10'd0,    32'sd0,           32'sd0,           1'b1, 1'b1}, // origin
        '{10'd1023, 10'd1023, Q_MAX,            Q_MAX,            1'b1, 1'b0},
        '{10'd0,    10'd1023, Q_MIN,            Q_MIN,            1'b1, 1'b0},
        '{10'd1023, 10'd0,    Q_MIN,            32'sd0,           1'b1, 1'b0},
        '{10'd512,  10'd511,  32'sd0,           Q_MAX,            1'b1, 1'b0},
        '{10'd341,  10'd682,  Q_MAX,            32'sd0,           1'b1, 1'b0},
        '{10'd682,  10'd341,  32'sd0,           Q_MIN,            1'b1, 1'b0},
        '{10'd1,    10'd2,    -Q_TWO,           32'sd0,           1'b1, 1'b1}, // |z|^2 == 4
        '{10'd3,    10'd4,    Q_TWO,            32'sd0,           1'b1, 1'b0},
        '{10'd5,    10'd6,    -Q_ONE,           32'sd0,           1'b1, 1'b1}, // period two
        '{10'd7,    10'd8,    32'sd0,           Q_ONE,            1'b1, 1'b1}, // c = i
        '{10'd9,    10'd10,   32'sh0400_0000,   32'sd0,           1'b0, 1'b0}, // cusp
        '{10'd11,   10'd12,   32'sh0428_F5C3,   32'sd0,           1'b0, 1'b0},
        '{10'd13,   10'd14,   -32'sh0C00_0000,  32'sh0199_999A,   1'b0, 1'b0},
        '{10'd15,   10'd16,   32'sd0,           -Q_ONE,           1'b0, 1'b0},
        '{10'd17,   10'd18,   -Q_TWO,           32'sd1,           1'b0, 1'b0},
        '{10'h2AA,  10'h155,  32'sh04CC_CCCD,   32'sh0800_0000,   1'b0, 1'b0},
        '{10'h155,  10'h2AA,  -32'sh1400_0000,  -32'sd1,          1'b0, 1'b0}
    };

    logic                clk         = 1'b0;
    logic                rst_n       = 1'b0;
    logic                in_valid    = 1'b0;
    logic                in_stall;
    t_in_item            in_item     = '0;
    logic                out_valid;
    logic                out_stall   = 1'b0;
    t_out_item           out_item;
    logic                cfg_we      = 1'b0;
    logic [ROUNDS_W-1:0] cfg_wdata   = '0;

    // Local copy of the round limit and the results still owed by the block.
    logic [ROUNDS_W-1:0] round_limit;
    t_out_item           pending_pixels [$];
    t_out_item           want;

    int errors          = 0;
    int pixels_sent     = 0;
    int results_checked = 0;
    int inside_count    = 0;
    int limits_used     = 0;
    int burst_left      = 0;

    // Receiver state: a long hold is requested by the main sequence and then
    // counted down here; otherwise stall runs and free runs follow in random order.
    int hold_request = 0;
    int hold_left    = 0;
    int seg_left     = 0;
    bit seg_stall    = 1'b0;
    int seg_pick;

    mandelbrot_membership_test_top dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_item  (out_item),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata)
    );

    always begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    // Saturate a wide intermediate to the signed 32-bit range of z.
    function automatic longint clamp_z(input longint v);
        if (v > Z_HI) begin
            return Z_HI;
        end
        if (v < Z_LO) begin
            return Z_LO;
        end
        return v;
    endfunction

    // Iterate z = z*z + c from zero; 0 as soon as |z|^2 exceeds four, else 1.
    // Arithmetic shifts of signed 64-bit values give the floor the block uses.
    function automatic logic stays_bounded(input logic signed [Z_W-1:0] cr,
                                           input logic signed [Z_W-1:0] ci,
                                           input logic [ROUNDS_W-1:0] rounds);
        longint zr;
        longint zi;
        longint rr;
        longint ii;
        longint ri;
        longint mag;
        int     n;
        zr = 0;
        zi = 0;
        for (n = 0; n < int'(rounds); n++) begin
            rr = zr * zr;
            ii = zi * zi;
            ri = zr * zi;
            zr = clamp_z(((rr - ii) >>> FRAC_BITS) + longint'(cr));
            zi = clamp_z((ri >>> (FRAC_BITS - 1)) + longint'(ci));
            mag = ((zr * zr) >>> FRAC_BITS) + ((zi * zi) >>> FRAC_BITS);
            if (mag > BAILOUT) begin
                return 1'b0;
            end
        end
        return 1'b1;
    endfunction

    function automatic t_out_item predict_pixel(input t_in_item p);
        t_out_item r;
        r.out_x  = p.pixel_x;
        r.out_y  = p.pixel_y;
        r.in_set = stays_bounded(p.c_real, p.c_imag, round_limit);
        return r;
    endfunction

    // Most points come from the neighborhood of the set so that orbits run for
    // a while; some span the square -2..2, a share sits in the main bulbs and
    // runs to the limit, and the rest uses every bit of c, which nearly always escapes at once.
    function automatic t_in_item random_pixel();
        t_in_item p;
        int       kind;
        p.pixel_x = PIX_W'($urandom_range(0, 1023));
        p.pixel_y = PIX_W'($urandom_range(0, 1023));
        kind = $urandom_range(0, 19);
        if (kind < 12) begin
            p.c_real = int'($urandom_range(0, 5 * ONE / 2)) - 2 * ONE;
            p.c_imag = int'($urandom_range(0, 5 * ONE / 2)) - 5 * ONE / 4;
        end else if (kind < 15) begin
            p.c_real = int'($urandom_range(0, 4 * ONE)) - 2 * ONE;
            p.c_imag = int'($urandom_range(0, 4 * ONE)) - 2 * ONE;
        end else if (kind < 17) begin
            p.c_real = int'($urandom_range(0, ONE / 2)) - ONE / 4 - ((kind == 16) ? ONE : 0);
            p.c_imag = int'($urandom_range(0, ONE / 8)) - ONE / 16;
        end else begin
            p.c_real = $urandom();
            p.c_imag = $urandom();
        end
        return p;
    endfunction

    // Offer one item and hold it until the block takes it, then maybe leave a
    // gap. Bursts of back-to-back items alternate with gaps of random length.
    task automatic offer_pixel(input t_in_item pix, input t_out_item expected_out);
        int gap;
        in_item  = pix;
        in_valid = 1'b1;
        do begin
            @(posedge clk);
        end while (in_stall !== 1'b0);
        pending_pixels = {pending_pixels, expected_out};
        pixels_sent++;
        @(negedge clk);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            gap = $urandom_range(0, 12);
            if (gap > 0) begin
                in_valid = 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 10);
        end
    endtask

    task automatic send_random_pixels(input int count);
        t_in_item p;
        repeat (count) begin
            p = random_pixel();
            offer_pixel(p, predict_pixel(p));
        end
    endtask

    // Stop offering and wait until every result owed has come out.
    task automatic wait_for_results();
        in_valid = 1'b0;
        while (pending_pixels.size() != 0) @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    // The round limit is only written with the block idle.
    task automatic load_round_limit(input logic [ROUNDS_W-1:0] limit);
        wait_for_results();
        cfg_wdata = limit;
        cfg_we    = 1'b1;
        @(negedge clk);
        cfg_we      = 1'b0;
        round_limit = limit;
        limits_used++;
    endtask

    // Receiver: drives the output stall at the falling edge.
    always @(negedge clk) begin
        if (hold_request > 0) begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            out_stall <= 1'b1;
        end else begin
            if (seg_left == 0) begin
                seg_pick = $urandom_range(0, 9);
                if (seg_pick < 2) begin
                    // A calm stretch with no stalling at all.
                    seg_stall = 1'b0;
                    seg_left  = $urandom_range(40, 200);
                end else if (seg_pick < 6) begin
                    seg_stall = 1'b1;
                    seg_left  = $urandom_range(1, 8);
                end else begin
                    seg_stall = 1'b0;
                    seg_left  = $urandom_range(1, 10);
                end
            end
            seg_left--;
            out_stall <= seg_stall;
        end
    end

    task automatic report_field(input string name, input int expected_val, input int got);
        if (expected_val != got) begin
            errors++;
            $display("%0t: mismatch on %s: expected %0d, got %0d", $time, name,
                     expected_val, got);
        end
    endtask

    // Checker: every result taken is compared with the oldest expectation.
    always @(posedge clk) begin
        if (rst_n && out_valid === 1'b1 && out_stall == 1'b0) begin
            if (pending_pixels.size() == 0) begin
                errors++;
                $display("%0t: unexpected result: expected none, got x=%0d y=%0d in_set=%0b",
                         $time, out_item.out_x, out_item.out_y, out_item.in_set);
            end else begin
                want = pending_pixels.pop_front();
                results_checked++;
                if (out_item.in_set === 1'b1) begin
                    inside_count++;
                end
                if (out_item !== want) begin
                    if ($isunknown(out_item)) begin
                        errors++;
                        $display("%0t: unknown bits in result: expected %h, got %h",
                                 $time, want, out_item);
                    end else begin
                        report_field("out_x", int'(want.out_x), int'(out_item.out_x));
                        report_field("out_y", int'(want.out_y), int'(out_item.out_y));
                        report_field("in_set", int'(want.in_set), int'(out_item.in_set));
                    end
                end
            end
        end
    end

    // Main sequence.
    initial begin
        t_in_item  p;
        t_out_item r;
        int        k;
        int        phase;

        // Synchronous reset, held low from time zero, released at a falling edge.
        round_limit = RESET_ROUNDS;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed points at the reset limit of 500 rounds.
        for (k = 0; k < N_PROBES; k++) begin
            p.pixel_x = PROBES[k].px;
            p.pixel_y = PROBES[k].py;
            p.c_real  = PROBES[k].cr;
            p.c_imag  = PROBES[k].ci;
            if (PROBES[k].known) begin
                r.out_x  = PROBES[k].px;
                r.out_y  = PROBES[k].py;
                r.in_set = PROBES[k].in_set;
            end else begin
                r = predict_pixel(p);
            end
            offer_pixel(p, r);
        end

        // Zero rounds: nothing is iterated, so every point reports as inside,
        // even the far corners of the plane.
        load_round_limit('0);
        p = '{pixel_x: 10'd1023, pixel_y: 10'd0, c_real: Q_MAX, c_imag: Q_MIN};
        offer_pixel(p, predict_pixel(p));
        send_random_pixels(5);

        // The largest limit; few points, since members run 4095 rounds each.
        load_round_limit('1);
        p = '{pixel_x: 10'd0, pixel_y: 10'd1023, c_real: 32'sd0, c_imag: 32'sd0};
        offer_pixel(p, predict_pixel(p));
        send_random_pixels(3);

        // A single round: only the escape test on c itself.
        load_round_limit(ROUNDS_W'(1));
        send_random_pixels(30);

        // Back-pressure: the receiver holds off long enough for the output
        // register and the finished next result to fill, so the input stalls
        // while items keep being offered.
        load_round_limit(ROUNDS_W'(8));
        @(posedge clk);
        hold_request = 300;
        @(negedge clk);
        send_random_pixels(24);

        // Bulk of the random run over a spread of small limits.
        for (phase = 0; phase < 8; phase++) begin
            load_round_limit(ROUNDS_W'($urandom_range(2, 64)));
            send_random_pixels(20);
            if (phase == 3) begin
                // Let the block drain completely before going on.
                wait_for_results();
            end
            send_random_pixels(20);
        end

        // Back to the power-up value written explicitly.
        load_round_limit(RESET_ROUNDS);
        send_random_pixels(15);

        wait_for_results();
        // Anything still coming out now would be an extra result.
        repeat (4 * int'(round_limit) + 16) @(negedge clk);

        $display("Sent %0d points under %0d round limits, zero and 4095 among them,",
                 pixels_sent, limits_used + 1);
        $display("with %0d results checked (%0d inside, %0d escaped) and %0d mismatches.",
                 results_checked, inside_count, results_checked - inside_count, errors);
        if (errors == 0) begin
            $display("** mandelbrot_membership_test_top: PASSED **");
        end else begin
            $display("** mandelbrot_membership_test_top: FAILED **");
        end
        $finish;
    end

    // Watchdog: ends the run if it outlasts the slowest correct run, with every
    // point running to its limit and every stall at its longest.
    initial begin
        #8_000_000;
        $display("Timed out with %0d results still pending.", pending_pixels.size());
        $display("** mandelbrot_membership_test_top: FAILED **");
        $finish;
    end

endmodule
